// File: hdl/bpi_pkg.sv
// Package for the BMP pixel inverter stream block.
// Holds the beat structs, the phase and byte-kind codes and the header constants.
// No dependencies.
`timescale 1ns / 1ps

package bpi_pkg;

    localparam int HEADER_BYTES_DEF = 54;
    localparam int WIDTH_OFS        = 18;   // first of three width bytes, low byte first
    localparam int HEIGHT_OFS       = 22;   // first of three height bytes, low byte first
    localparam int DIM_W            = 24;
    localparam int ROWB_W           = 26;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
        logic       image_last;
    } out_item_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_PAD    = 2'd2
    } byte_kind_t;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_PIXEL  = 4'b0010,
        PH_PAD    = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    // Result of the parser for the beat in the input register.
    typedef struct packed {
        logic      emit;
        out_item_t item;
    } parse_res_t;

endpackage

// File: hdl/bmp_pixel_inverter_stream_core.sv
// Top level of the BMP pixel inverter stream block.
// Instantiates bpi_in_reg, bpi_parser and bpi_out_reg; uses bpi_pkg.
//
// Usage: the s_ channel carries a 24-bit BMP file one byte per beat, with
// file_start raised on the first byte of each file. The m_ channel returns
// one beat per header, pixel or padding byte: header bytes unchanged, pixel
// bytes inverted, padding bytes unchanged, and image_last on the final image
// byte. Bytes after the image, or after a header with zero width or height,
// give no result beat.
// A byte accepted into the input register passes through the parser into the
// result register, which drives m_valid.
// Throughput: one byte per cycle while m_ready stays high; the parser forms
// each result and its next counter state combinationally between the registers.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to the header of a new file. When the receiver holds m_ready low,
// the result register keeps its beat, and one more byte is held in the
// input register before s_ready falls.
`timescale 1ns / 1ps

module bmp_pixel_inverter_stream_core #(
    parameter int HEADER_BYTES = bpi_pkg::HEADER_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bpi_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bpi_pkg::out_item_t m_data
);
    import bpi_pkg::*;

    logic       item_valid;
    in_item_t   item;
    parse_res_t res;
    logic       out_free;
    logic       advance;

    // A beat that produces no result moves on even while the output stalls.
    assign advance = item_valid && (!res.emit || out_free);

    bpi_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bpi_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .advance (advance),
        .res     (res)
    );

    bpi_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && res.emit),
        .item    (res.item),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // The last image byte is always a pixel or padding byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.image_last |-> m_data.byte_kind != KIND_HEADER)
        else $error("bmp_pixel_inverter_stream_core: image_last on a header byte");

    // A beat accepted into an empty input register is presented next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> item_valid)
        else $error("bmp_pixel_inverter_stream_core: accepted beat lost");

    // Inverted pixels are the complement of the byte taken from the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.emit && res.item.byte_kind == KIND_PIXEL
        |-> res.item.out_byte == ~item.data_byte)
        else $error("bmp_pixel_inverter_stream_core: pixel byte not inverted");

endmodule

// File: hdl/bpi_in_reg.sv
// Input register stage of the BMP pixel inverter stream block.
// Depends on bpi_pkg for the input beat struct.
`timescale 1ns / 1ps

module bpi_in_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bpi_pkg::in_item_t s_data,
    input  logic             advance,
    output logic             item_valid,
    output bpi_pkg::in_item_t item
);
    import bpi_pkg::*;

    logic     valid_reg;
    in_item_t data_reg;

    // The register can take a new beat when empty or when its beat moves on now.
    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> valid_reg)
        else $error("bpi_in_reg: beat advanced from an empty register");

endmodule

// File: hdl/bpi_parser.sv
// Parser state and per-beat decision logic of the BMP pixel inverter stream block.
// Depends on bpi_pkg for codes, constants and structs.
`timescale 1ns / 1ps

module bpi_parser #(
    parameter int HEADER_BYTES = bpi_pkg::HEADER_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpi_pkg::in_item_t   item,
    input  logic                advance,
    output bpi_pkg::parse_res_t res
);
    import bpi_pkg::*;

    localparam int HIDX_W = $clog2(HEADER_BYTES);
    localparam logic [HIDX_W-1:0] HIDX_LAST = HIDX_W'(HEADER_BYTES - 1);

    phase_t              phase_reg, phase_next, phase_cur;
    logic [HIDX_W-1:0]   hidx_reg, hidx_next, hidx_cur;
    logic [DIM_W-1:0]    width_reg, width_next, width_cur;
    logic [DIM_W-1:0]    height_reg, height_next, height_cur;
    logic [ROWB_W-1:0]   width3_reg, width3_next;
    logic [ROWB_W-1:0]   rbc_reg, rbc_next, rbc_inc;
    logic [DIM_W-1:0]    rows_reg, rows_next, rows_inc;
    logic [1:0]          align_reg, align_next, align_inc;
    logic [7:0]          b;

    always_comb begin
        b          = item.data_byte;
        // A start flag clears the parse and takes this beat as header byte 0.
        phase_cur  = item.file_start ? PH_HEADER : phase_reg;
        hidx_cur   = item.file_start ? '0 : hidx_reg;
        width_cur  = item.file_start ? '0 : width_reg;
        height_cur = item.file_start ? '0 : height_reg;

        rbc_inc    = rbc_reg + ROWB_W'(1);
        rows_inc   = rows_reg + DIM_W'(1);
        align_inc  = align_reg + 2'd1;

        phase_next  = phase_cur;
        hidx_next   = hidx_cur;
        width_next  = width_cur;
        height_next = height_cur;
        width3_next = width3_reg;
        rbc_next    = rbc_reg;
        rows_next   = rows_reg;
        align_next  = align_reg;

        res                 = '0;
        res.item.out_byte   = b;
        res.item.byte_kind  = KIND_HEADER;
        res.item.image_last = 1'b0;

        unique case (phase_cur)
            PH_HEADER: begin
                if (hidx_cur == HIDX_W'(WIDTH_OFS))      width_next[7:0]    = b;
                if (hidx_cur == HIDX_W'(WIDTH_OFS + 1))  width_next[15:8]   = b;
                if (hidx_cur == HIDX_W'(WIDTH_OFS + 2))  width_next[23:16]  = b;
                if (hidx_cur == HIDX_W'(HEIGHT_OFS))     height_next[7:0]   = b;
                if (hidx_cur == HIDX_W'(HEIGHT_OFS + 1)) height_next[15:8]  = b;
                if (hidx_cur == HIDX_W'(HEIGHT_OFS + 2)) height_next[23:16] = b;
                if (hidx_cur == HIDX_LAST) begin
                    hidx_next   = '0;
                    rbc_next    = '0;
                    rows_next   = '0;
                    align_next  = '0;
                    width3_next = ROWB_W'({width_next, 1'b0}) + ROWB_W'(width_next);
                    phase_next  = (width_next == '0 || height_next == '0) ? PH_DONE
                                                                          : PH_PIXEL;
                end else begin
                    hidx_next = hidx_cur + HIDX_W'(1);
                end
                res.emit = 1'b1;
            end
            PH_PIXEL: begin
                rbc_next   = rbc_inc;
                align_next = align_inc;
                if (rbc_inc >= width3_reg) begin
                    rbc_next  = '0;
                    rows_next = rows_inc;
                    if (align_inc == 2'd0) begin
                        if (rows_inc >= height_reg) begin
                            phase_next          = PH_DONE;
                            res.item.image_last = 1'b1;
                        end else begin
                            phase_next = PH_PIXEL;
                        end
                    end else begin
                        phase_next = PH_PAD;
                    end
                end
                res.emit           = 1'b1;
                res.item.out_byte  = ~b;
                res.item.byte_kind = KIND_PIXEL;
            end
            PH_PAD: begin
                align_next = align_inc;
                if (align_inc == 2'd0) begin
                    if (rows_reg >= height_reg) begin
                        phase_next          = PH_DONE;
                        res.item.image_last = 1'b1;
                    end else begin
                        phase_next = PH_PIXEL;
                    end
                end
                res.emit           = 1'b1;
                res.item.byte_kind = KIND_PAD;
            end
            PH_DONE: begin
                res.emit = 1'b0;
            end
            default: begin
                res.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            hidx_reg   <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            width3_reg <= '0;
            rbc_reg    <= '0;
            rows_reg   <= '0;
            align_reg  <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            hidx_reg   <= hidx_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            width3_reg <= width3_next;
            rbc_reg    <= rbc_next;
            rows_reg   <= rows_next;
            align_reg  <= align_next;
        end
    end

    // The header index only moves while the header is being parsed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_HEADER |-> hidx_reg == '0)
        else $error("bpi_parser: header index left non-zero outside the header");

    // Padding is only entered off a 4-byte boundary and left on one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAD |-> align_reg != 2'd0)
        else $error("bpi_parser: padding phase on an aligned count");

    // The row counter wraps before it reaches the row length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PIXEL |-> rbc_reg < width3_reg)
        else $error("bpi_parser: row byte count overran the row length");

    // Leaving the header clears the row and alignment counters.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && phase_cur == PH_HEADER && hidx_cur == HIDX_LAST
        |=> rbc_reg == '0 && align_reg == 2'd0 && rows_reg == '0)
        else $error("bpi_parser: counters not cleared at the end of the header");

endmodule

// File: hdl/bpi_out_reg.sv
// Result register stage of the BMP pixel inverter stream block.
// Depends on bpi_pkg for the result beat struct.
`timescale 1ns / 1ps

module bpi_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  bpi_pkg::out_item_t item,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output bpi_pkg::out_item_t m_data
);
    import bpi_pkg::*;

    logic      valid_reg;
    out_item_t data_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && free) begin
            data_reg <= item;
        end
    end

    // A result is never loaded over one that the receiver has not taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("bpi_out_reg: result loaded over a stalled beat");

endmodule
